### rtl/core/ptws_pkg.sv
// Shared types and codes for the prefix tree word store.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package ptws_pkg;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_PREFIX = 2'd2,
    MODE_NONE   = 2'd3
  } ptws_mode_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } ptws_state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr;     // clearing pass, one table entry per cycle
    logic load;    // item accepted, child lookup issued
    logic walk;    // child data back, step the cursor
    logic finish;  // last letter: produce the result, end the walk
  } ptws_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic need_finish;
    logic out_free;
  } ptws_sts_t;

endpackage

### rtl/core/ptws_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ptws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/ptws_ctrl.sv
// Sequencer for the prefix tree word store: clearing pass, accept, walk, finish.
// Depends on ptws_pkg.
`timescale 1ns / 1ps

module ptws_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ptws_pkg::ptws_sts_t sts,
  output ptws_pkg::ptws_cmd_t cmd
);

  import ptws_pkg::*;

  ptws_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk  = 1'b1;
        state_nxt = sts.need_finish ? ST_FINISH : ST_IDLE;
      end
      ST_FINISH: begin
        // hold here until the output register can take the result
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

### rtl/core/ptws_dpath.sv
// Datapath for the prefix tree word store: child table, end marks, walk state,
// node allocator and output register. Depends on ptws_pkg and ptws_ram.
`timescale 1ns / 1ps

module ptws_dpath #(
  parameter int NODES    = 1024,
  parameter int ALPHABET = 26
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ptws_pkg::ptws_cmd_t cmd,
  output ptws_pkg::ptws_sts_t sts,
  input  logic [1:0]          in_mode,
  input  logic [4:0]          in_letter,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_found,
  output logic                out_full_res
);

  import ptws_pkg::*;

  localparam int DEPTH = NODES * ALPHABET;
  localparam int IW    = $clog2(NODES);
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] ALPHA_C  = AW'(ALPHABET);
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);
  localparam logic [AW:0]   NODES_A  = (AW + 1)'(NODES);
  localparam logic [IW:0]   NODES_I  = (IW + 1)'(NODES);

  // item and walk state
  ptws_mode_t      mode_r;
  logic            last_r;
  logic            lv_r;
  logic [AW-1:0]   slot_r;
  logic [IW-1:0]   cursor_r, cursor_nxt;
  logic [IW:0]     used_r, used_nxt;
  logic            missed_r, missed_nxt;
  logic            exh_r, exh_nxt;
  logic [AW-1:0]   clr_cnt_r;
  logic            out_valid_r, out_valid_nxt;
  logic            out_found_r, out_full_r;

  logic [AW-1:0]   slot_in;
  logic [IW-1:0]   child_q;
  logic            end_q;
  logic            alloc;
  logic            child_we;
  logic [AW-1:0]   child_wa;
  logic [IW-1:0]   child_wd;
  logic            end_we;
  logic [IW-1:0]   end_wa;
  logic            set_end;
  logic            out_free;

  assign slot_in  = cursor_r * ALPHA_C + AW'(in_letter);
  assign out_free = !out_valid_r || out_ready;

  // one step of the walk, evaluated with the child entry just read; finish resets the walk
  always_comb begin
    cursor_nxt = cursor_r;
    used_nxt   = used_r;
    missed_nxt = missed_r;
    exh_nxt    = exh_r;
    alloc      = 1'b0;
    if (cmd.walk) begin
      if (mode_r == MODE_NONE) begin
        if (last_r) begin
          cursor_nxt = '0;
          missed_nxt = 1'b0;
          exh_nxt    = 1'b0;
        end
      end else if (!missed_r) begin
        if (!lv_r) begin
          missed_nxt = 1'b1;
        end else if (child_q != '0) begin
          cursor_nxt = child_q;
        end else if (mode_r == MODE_INSERT) begin
          if (used_r < NODES_I) begin
            alloc      = 1'b1;
            cursor_nxt = used_r[IW-1:0];
            used_nxt   = used_r + 1'b1;
          end else begin
            exh_nxt    = 1'b1;
            missed_nxt = 1'b1;
          end
        end else begin
          missed_nxt = 1'b1;
        end
      end
    end else if (cmd.finish) begin
      cursor_nxt = '0;
      missed_nxt = 1'b0;
      exh_nxt    = 1'b0;
    end
  end

  assign set_end = cmd.finish && (mode_r == MODE_INSERT) && !missed_r;

  always_comb begin
    child_we = cmd.clr || alloc;
    child_wa = cmd.clr ? clr_cnt_r : slot_r;
    child_wd = cmd.clr ? '0 : used_r[IW-1:0];
    end_we   = (cmd.clr && ({1'b0, clr_cnt_r} < NODES_A)) || set_end;
    end_wa   = cmd.clr ? clr_cnt_r[IW-1:0] : cursor_r;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= '0;
      used_r      <= (IW + 1)'(1);
      missed_r    <= 1'b0;
      exh_r       <= 1'b0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cursor_r    <= cursor_nxt;
      used_r      <= used_nxt;
      missed_r    <= missed_nxt;
      exh_r       <= exh_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= ptws_mode_t'(in_mode);
      last_r <= in_last;
      lv_r   <= ({2'b00, in_letter} < 7'(ALPHABET));
      slot_r <= slot_in;
    end
    if (cmd.finish) begin
      case (mode_r)
        MODE_INSERT: begin
          out_found_r <= !missed_r;
          out_full_r  <= exh_r;
        end
        MODE_SEARCH: begin
          out_found_r <= !missed_r && end_q;
          out_full_r  <= 1'b0;
        end
        default: begin
          out_found_r <= !missed_r;
          out_full_r  <= 1'b0;
        end
      endcase
    end
  end

  ptws_ram #(
    .WIDTH (IW),
    .DEPTH (DEPTH)
  ) u_child_ram (
    .clk     (clk),
    .wr_en   (child_we),
    .wr_addr (child_wa),
    .wr_data (child_wd),
    .rd_en   (cmd.load),
    .rd_addr (slot_in),
    .rd_data (child_q)
  );

  // end mark of the node the walk lands on; read during walk, used at finish
  ptws_ram #(
    .WIDTH (1),
    .DEPTH (NODES)
  ) u_end_ram (
    .clk     (clk),
    .wr_en   (end_we),
    .wr_addr (end_wa),
    .wr_data (!cmd.clr),
    .rd_en   (cmd.walk),
    .rd_addr (cursor_nxt),
    .rd_data (end_q)
  );

  assign sts.clr_done    = (clr_cnt_r == CLR_LAST);
  assign sts.need_finish = last_r && (mode_r != MODE_NONE);
  assign sts.out_free    = out_free;

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_full_res = out_full_r;

endmodule

### rtl/core/prefix_tree_word_store.sv
// Prefix tree word store over a lowercase alphabet, one letter per item.
// A letter that is not the last of its word is accepted and issues the child
// lookup; the lookup returns from the registered child-table RAM and the cursor
// steps, reading the end mark of the reached node. A last letter (in any mode
// but MODE_NONE) then loads the result once the output register is free.
// The registered child-table read is what sets the per-letter cost.
// After reset the block runs a clearing pass over both tables (NODES*ALPHABET
// child-table entries, 26624 by default) and accepts no item until it is done.
`timescale 1ns / 1ps

module prefix_tree_word_store #(
  parameter int NODES    = 1024,
  parameter int ALPHABET = 26
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [4:0] in_letter,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_found,
  output logic       out_full_res
);

  import ptws_pkg::*;

  ptws_cmd_t cmd;
  ptws_sts_t sts;

  ptws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptws_dpath #(
    .NODES    (NODES),
    .ALPHABET (ALPHABET)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_mode      (in_mode),
    .in_letter    (in_letter),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_found    (out_found),
    .out_full_res (out_full_res)
  );

endmodule
